### hw/rtl/sqt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_pkg - shared types and constants of the scan-code queue translator
// Queue geometry, scan-code constants, command codes and the set 1 character
// ROM with its lookup helpers.
// ----------------------------------------------------------------------------
package sqt_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// command codes
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// scan codes of interest
	localparam logic [7:0] SC_ESC     = 8'h01;
	localparam logic [7:0] SC_LSHIFT  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT  = 8'h36;
	localparam logic [7:0] SC_CAPS    = 8'h3A;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] ROM_SIZE   = 8'd58;

	// character ROM, {upper, lower} per make code; padded to 64 entries
	localparam logic [15:0] CHAR_ROM [64] = '{
		16'h0000, 16'h1B1B, 16'h2131, 16'h4032, 16'h2333, 16'h2434, 16'h2535, 16'h5E36,
		16'h2637, 16'h2A38, 16'h2839, 16'h2930, 16'h5F2D, 16'h2B3D, 16'h0808, 16'h0909,
		16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
		16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h0A0A, 16'h0000, 16'h4161, 16'h5373,
		16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B,
		16'h2227, 16'h7E60, 16'h0000, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
		16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F, 16'h0000, 16'h0000,
		16'h0000, 16'h2020, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
	};

	// queue control from the sequencer
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [7:0] wdata;
	} q_ctrl_t;

	// queue status back to the sequencer
	typedef struct packed {
		logic       empty;
		logic [7:0] rdata;
	} q_stat_t;

	// one result transaction
	typedef struct packed {
		logic       escape_pulse;
		logic       has_events;
		logic       char_valid;
		logic [7:0] char_code;
		logic [7:0] raw_event;
	} result_t;

	// printable make code: 1..57, not a shift key
	function automatic logic is_char_code(input logic [7:0] b);
		return (b != 8'd0) && (b < ROM_SIZE) && (b != SC_LSHIFT) && (b != SC_RSHIFT);
	endfunction

	function automatic logic [7:0] rom_char(input logic [7:0] b, input logic upper);
		logic [15:0] entry;
		entry = CHAR_ROM[b[5:0]];
		return upper ? entry[15:8] : entry[7:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/scancode_queue_translator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_queue_translator - keyboard event queue with set 1 translation
// Input channel s_*: one command per transaction (push, pop raw, read char).
// Output channel m_*: exactly one result transaction per command.
// Timing: a command is taken when s_tready is high, which is only while no
// command is in progress. The command is registered, then executed: a push,
// an unused command or a read of an empty ring completes in the execute
// state; a raw pop issues the pop there and completes in the pop-data state
// from the ring's registered read port; a read-char drains bytes one by one,
// each through the ring's registered read port and the code check, and ends
// on the first character or when the ring runs out, with an empty result.
// s_tready returns in the same cycle as m_tvalid rises.
// Back-pressure: a finished result sits in the output register until taken;
// the next command is accepted meanwhile, but it cannot complete until the
// register is free.
// Reset: arst_n clears the ring's slots and count, shift and caps lock and
// the output valid. Ring contents are not cleared; no clearing pass is run.
// ----------------------------------------------------------------------------
module scancode_queue_translator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] scancode
	input  wire logic [1:0]  s_tuser,  // [1:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // [7:0] raw_event, [15:8] char_code,
	                                   // [16] has_events, [17] escape_pulse
	output logic             m_tuser   // [0] char_valid
);

	sqt_pkg::q_ctrl_t q_ctrl;
	sqt_pkg::q_stat_t q_stat;
	sqt_pkg::result_t res;

	sqt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (s_tuser),
		.in_scancode (s_tdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res),
		.q_ctrl      (q_ctrl),
		.q_stat      (q_stat)
	);

	sqt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.stat   (q_stat)
	);

	// result packing
	assign m_tdata = {6'd0, res.escape_pulse, res.has_events, res.char_code, res.raw_event};
	assign m_tuser = res.char_valid;

endmodule
`default_nettype wire

### hw/rtl/sqt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_queue - overwriting ring buffer of scan-code bytes
// One write port and one registered read port. A push into a full ring
// drops the oldest byte. Pops are only issued when the ring holds data.
// ----------------------------------------------------------------------------
module sqt_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sqt_pkg::q_ctrl_t ctrl,
	output sqt_pkg::q_stat_t     stat
);

	logic [7:0]                mem_q [sqt_pkg::QUEUE_DEPTH];
	logic [sqt_pkg::PTR_W-1:0] wr_q;
	logic [sqt_pkg::PTR_W-1:0] rd_q;
	logic [sqt_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                rdata_q;
	logic [sqt_pkg::PTR_W-1:0] wr_next;
	logic [sqt_pkg::PTR_W-1:0] rd_next;

	// wrapping slot increment
	assign wr_next = (wr_q == sqt_pkg::PTR_LAST) ? '0 : wr_q + 1'b1;
	assign rd_next = (rd_q == sqt_pkg::PTR_LAST) ? '0 : rd_q + 1'b1;

	// storage with registered read
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[wr_q] <= ctrl.wdata;
		end
		if (ctrl.pop) begin
			rdata_q <= mem_q[rd_q];
		end
	end

	// slots and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (ctrl.push) begin
			wr_q <= wr_next;
			if (cnt_q != sqt_pkg::CNT_FULL) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				rd_q <= rd_next;
			end
		end else if (ctrl.pop) begin
			rd_q  <= rd_next;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign stat.empty = (cnt_q == '0);
	assign stat.rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/sqt_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_seq - command sequencer of the scan-code queue translator
// Runs one command at a time against the queue, tracks shift and caps lock,
// walks the queue for a read-char command and holds the result register.
// ----------------------------------------------------------------------------
module sqt_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [1:0]      in_cmd,
	input  wire logic [7:0]      in_scancode,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sqt_pkg::result_t     out_res,
	output sqt_pkg::q_ctrl_t     q_ctrl,
	input  wire sqt_pkg::q_stat_t q_stat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_POPD = 2'd2;
	localparam logic [1:0] ST_CHK  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [1:0]       cmd_q;
	logic [7:0]       sc_q;
	logic             shift_q, shift_d;
	logic             caps_q, caps_d;
	logic             out_valid_q;
	sqt_pkg::result_t res_q, res_d;
	logic             commit;
	logic             out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// sequencer
	always_comb begin
		state_d      = state_q;
		shift_d      = shift_q;
		caps_d       = caps_q;
		commit       = 1'b0;
		res_d        = '0;
		q_ctrl.push  = 1'b0;
		q_ctrl.pop   = 1'b0;
		q_ctrl.wdata = sc_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (cmd_q) inside
					sqt_pkg::CMD_PUSH: begin
						if (out_free) begin
							q_ctrl.push      = 1'b1;
							commit           = 1'b1;
							res_d.has_events = 1'b1;
							if (sc_q == sqt_pkg::SC_LSHIFT || sc_q == sqt_pkg::SC_RSHIFT) begin
								shift_d = 1'b1;
							end else if (sc_q == sqt_pkg::SC_LSHIFT_BRK
									|| sc_q == sqt_pkg::SC_RSHIFT_BRK) begin
								shift_d = 1'b0;
							end else if (sc_q == sqt_pkg::SC_CAPS) begin
								caps_d = !caps_q;
							end else if (sc_q == sqt_pkg::SC_ESC) begin
								res_d.escape_pulse = 1'b1;
							end
							state_d = ST_IDLE;
						end
					end
					sqt_pkg::CMD_POP, sqt_pkg::CMD_READ: begin
						if (!q_stat.empty) begin
							q_ctrl.pop = 1'b1;
							state_d    = (cmd_q == sqt_pkg::CMD_POP) ? ST_POPD : ST_CHK;
						end else if (out_free) begin
							// nothing queued: empty result
							commit  = 1'b1;
							state_d = ST_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							commit           = 1'b1;
							res_d.has_events = !q_stat.empty;
							state_d          = ST_IDLE;
						end
					end
				endcase
			end
			ST_POPD: begin
				if (out_free) begin
					commit           = 1'b1;
					res_d.raw_event  = q_stat.rdata;
					res_d.has_events = !q_stat.empty;
					state_d          = ST_IDLE;
				end
			end
			ST_CHK: begin
				if (sqt_pkg::is_char_code(q_stat.rdata)) begin
					if (out_free) begin
						commit           = 1'b1;
						res_d.char_valid = 1'b1;
						res_d.char_code  = sqt_pkg::rom_char(q_stat.rdata, shift_q | caps_q);
						res_d.has_events = !q_stat.empty;
						state_d          = ST_IDLE;
					end
				end else begin
					// not a character: discard and fetch the next byte
					state_d = ST_EXEC;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			shift_q     <= 1'b0;
			caps_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			shift_q <= shift_d;
			caps_q  <= caps_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command capture and result register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= in_cmd;
			sc_q  <= in_scancode;
		end
		if (commit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

### hw/rtl/sqt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqt_checker - port-level checks of the scan-code queue translator
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sqt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser
);

	// no result while held in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// one command in flight: no accept on the cycle after an accept
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command accepted while busy");

	// a character result carries no raw byte or escape, else no character
	a_char_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser ? (m_tdata[7:0] == 8'd0 && !m_tdata[17])
			: (m_tdata[15:8] == 8'd0)))
		else $error("inconsistent character result");

	// escape only comes from a push, which always leaves events queued
	a_esc_events: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> m_tdata[16])
		else $error("escape without queued events");

endmodule

bind scancode_queue_translator sqt_checker u_sqt_checker (.*);
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the scan-code queue translator
// A directed table covers the empty queue, the unused command, ESC, shift,
// caps lock, break codes and ROM holes. Random typing, overflow bursts and
// noise follow. Each command is run through a local model of the ring and
// the set 1 character table; every result is compared with the oldest
// prediction field by field. Both sides idle in random bursts until QUIET_FROM.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] CMD_NONE   = 2'd3;
	localparam int         KEY_COUNT  = 58;
	localparam int         TOTAL_CMDS = 1500;
	localparam int         QUIET_FROM = 1300;
	localparam int         STALL_MAX  = 5000;

	// set 1 characters, make code 0 in the top byte down to 57 in the bottom one
	localparam logic [8*KEY_COUNT-1:0] LOWER_KEYS = {
		64'h001B313233343536, 64'h373839302D3D0809, 64'h7177657274797569,
		64'h6F705B5D0A006173, 64'h646667686A6B6C3B, 64'h2760005C7A786376,
		64'h626E6D2C2E2F0000, 16'h0020};
	localparam logic [8*KEY_COUNT-1:0] UPPER_KEYS = {
		64'h001B21402324255E, 64'h262A28295F2B0809, 64'h5157455254595549,
		64'h4F507B7D0A004153, 64'h444647484A4B4C3A, 64'h227E007C5A584356,
		64'h424E4D3C3E3F0000, 16'h0020};

	typedef struct packed {
		logic [7:0] raw_event;
		logic [7:0] char_code;
		logic       char_valid;
		logic       has_events;
		logic       escape_pulse;
	} key_result_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  scancode;
		bit          fixed;
		key_result_t want;
	} key_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tuser;

	// local copy of the keyboard state
	logic [7:0]  queued_keys[$];
	logic        shift_down;
	logic        caps_lock;

	key_result_t pending_results[$];
	key_row_t    directed_rows[$];
	int          mismatches;
	int          sent_count;
	bit          quiet;

	scancode_queue_translator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// printable make code: 1..57 and not a shift key
	function automatic bit is_printable(logic [7:0] code);
		return code != 8'd0 && code < KEY_COUNT && code != sqt_pkg::SC_LSHIFT
			&& code != sqt_pkg::SC_RSHIFT;
	endfunction

	function automatic logic [7:0] translate_key(logic [7:0] code, logic upper);
		int pos;
		pos = 8 * (KEY_COUNT - 1 - int'(code));
		return upper ? UPPER_KEYS[pos +: 8] : LOWER_KEYS[pos +: 8];
	endfunction

	// advance the keyboard state by one command and return its result
	function automatic key_result_t apply_command(logic [1:0] cmd, logic [7:0] code);
		key_result_t res;
		logic [7:0]  b;
		res = '0;
		case (cmd)
			sqt_pkg::CMD_PUSH: begin
				if (code == sqt_pkg::SC_LSHIFT || code == sqt_pkg::SC_RSHIFT)
					shift_down = 1'b1;
				else if (code == sqt_pkg::SC_LSHIFT_BRK || code == sqt_pkg::SC_RSHIFT_BRK)
					shift_down = 1'b0;
				else if (code == sqt_pkg::SC_CAPS)
					caps_lock = ~caps_lock;
				else if (code == sqt_pkg::SC_ESC)
					res.escape_pulse = 1'b1;
				// full ring: newest byte overwrites the oldest
				if (queued_keys.size() == sqt_pkg::QUEUE_DEPTH)
					void'(queued_keys.pop_front());
				queued_keys.push_back(code);
			end
			sqt_pkg::CMD_POP: begin
				if (queued_keys.size() > 0)
					res.raw_event = queued_keys.pop_front();
			end
			sqt_pkg::CMD_READ: begin
				while (queued_keys.size() > 0 && !res.char_valid) begin
					b = queued_keys.pop_front();
					if (is_printable(b)) begin
						res.char_code  = translate_key(b, shift_down | caps_lock);
						res.char_valid = 1'b1;
					end
				end
			end
			default: ;
		endcase
		res.has_events = queued_keys.size() > 0;
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
		$display("ERROR at %0t ns: %s got 0x%02h, expected 0x%02h", $time, field, got, want);
		mismatches++;
	endtask

	// drive one command transaction and record what it should produce
	task automatic send_command(logic [1:0] cmd, logic [7:0] code, bit fixed = 0,
			key_result_t want = '0);
		key_result_t predicted;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = code;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = apply_command(cmd, code);
		pending_results.push_back(fixed ? want : predicted);
		sent_count++;
		if (sent_count >= QUIET_FROM)
			quiet = 1;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(logic [1:0] cmd, logic [7:0] code);
		key_row_t row;
		row.cmd      = cmd;
		row.scancode = code;
		row.fixed    = 0;
		row.want     = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_fixed(logic [1:0] cmd, logic [7:0] code, logic [7:0] raw,
			logic [7:0] chr, logic valid, logic has, logic esc);
		key_row_t row;
		row.cmd      = cmd;
		row.scancode = code;
		row.fixed    = 1;
		row.want     = '{raw_event: raw, char_code: chr, char_valid: valid,
		                 has_events: has, escape_pulse: esc};
		directed_rows.push_back(row);
	endtask

	function automatic logic [7:0] random_make();
		return 8'($urandom_range(1, KEY_COUNT - 1));
	endfunction

	// stimulus
	initial begin
		int          mode;
		int          n;
		logic [7:0]  key;
		bit          halfway_done;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = sqt_pkg::CMD_PUSH;
		shift_down   = 1'b0;
		caps_lock    = 1'b0;
		mismatches   = 0;
		sent_count   = 0;
		quiet        = 0;
		halfway_done = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty queue, unused command and the basic keys
		add_fixed(sqt_pkg::CMD_POP,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		add_fixed(sqt_pkg::CMD_READ, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		add_fixed(CMD_NONE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
		add_fixed(sqt_pkg::CMD_PUSH, sqt_pkg::SC_ESC, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
		add_row(sqt_pkg::CMD_PUSH, 8'h00);
		add_row(sqt_pkg::CMD_PUSH, 8'hFF);
		add_row(sqt_pkg::CMD_PUSH, 8'h1E);
		add_fixed(sqt_pkg::CMD_READ, 8'h00, 8'h00, 8'h1B, 1'b1, 1'b1, 1'b0);
		add_fixed(sqt_pkg::CMD_READ, 8'h00, 8'h00, 8'h61, 1'b1, 1'b0, 1'b0);
		// shift held, then released; right shift and caps lock
		add_row(sqt_pkg::CMD_PUSH, sqt_pkg::SC_LSHIFT);
		add_row(sqt_pkg::CMD_PUSH, 8'h1E);
		add_row(sqt_pkg::CMD_READ, 8'h00);
		add_row(sqt_pkg::CMD_PUSH, sqt_pkg::SC_LSHIFT_BRK);
		add_row(sqt_pkg::CMD_PUSH, sqt_pkg::SC_RSHIFT);
		add_row(sqt_pkg::CMD_PUSH, sqt_pkg::SC_RSHIFT_BRK);
		add_row(sqt_pkg::CMD_PUSH, sqt_pkg::SC_CAPS);
		add_row(sqt_pkg::CMD_PUSH, 8'h39);
		add_row(sqt_pkg::CMD_PUSH, 8'h1D);
		add_row(sqt_pkg::CMD_READ, 8'h00);
		// control key has an empty ROM slot but still counts as a character
		add_fixed(sqt_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
		add_fixed(sqt_pkg::CMD_PUSH, sqt_pkg::SC_CAPS, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
		add_fixed(sqt_pkg::CMD_POP,  8'h00, sqt_pkg::SC_CAPS, 8'h00, 1'b0, 1'b0, 1'b0);
		add_row(sqt_pkg::CMD_PUSH, 8'h80);
		add_fixed(CMD_NONE, 8'h5A, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
		add_fixed(sqt_pkg::CMD_POP,  8'h00, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0);

		foreach (directed_rows[i])
			send_command(directed_rows[i].cmd, directed_rows[i].scancode,
				directed_rows[i].fixed, directed_rows[i].want);
		drain_results();

		// random episodes
		while (sent_count < TOTAL_CMDS) begin
			if (!halfway_done && sent_count >= TOTAL_CMDS / 2) begin
				drain_results();
				halfway_done = 1;
			end
			mode = $urandom_range(0, 9);
			case (mode)
				0: begin
					// push 40 to 80 keys or break codes only, which can fill past capacity, then read 1 to 4 times
					n = $urandom_range(40, 80);
					if ($urandom_range(0, 1)) begin
						repeat (n) send_command(sqt_pkg::CMD_PUSH, random_make());
					end else begin
						repeat (n) send_command(sqt_pkg::CMD_PUSH,
							8'($urandom_range(8'h80, 8'hFF)));
					end
					repeat ($urandom_range(1, 4))
						send_command(sqt_pkg::CMD_READ, 8'($urandom));
				end
				1: begin
					// shifted word
					key = $urandom_range(0, 1) ? sqt_pkg::SC_LSHIFT : sqt_pkg::SC_RSHIFT;
					send_command(sqt_pkg::CMD_PUSH, key);
					repeat ($urandom_range(1, 5)) begin
						n = random_make();
						send_command(sqt_pkg::CMD_PUSH, 8'(n));
						send_command(sqt_pkg::CMD_PUSH, 8'(n) | 8'h80);
						if ($urandom_range(0, 1))
							send_command(sqt_pkg::CMD_READ, 8'($urandom));
					end
					send_command(sqt_pkg::CMD_PUSH, key | 8'h80);
					repeat ($urandom_range(0, 3))
						send_command(sqt_pkg::CMD_READ, 8'($urandom));
				end
				2: begin
					send_command(sqt_pkg::CMD_PUSH, sqt_pkg::SC_CAPS);
					send_command(sqt_pkg::CMD_PUSH, sqt_pkg::SC_CAPS | 8'h80);
				end
				3: begin
					// noise: any command, any byte
					repeat ($urandom_range(1, 6))
						send_command(2'($urandom), 8'($urandom));
				end
				4: begin
					send_command(sqt_pkg::CMD_PUSH,
						$urandom_range(0, 1) ? sqt_pkg::SC_ESC : 8'($urandom));
					repeat ($urandom_range(1, 3))
						send_command(sqt_pkg::CMD_POP, 8'($urandom));
				end
				default: begin
					// plain typing: make, break, then maybe a read or a pop
					n = random_make();
					send_command(sqt_pkg::CMD_PUSH, 8'(n));
					send_command(sqt_pkg::CMD_PUSH, 8'(n) | 8'h80);
					case ($urandom_range(0, 3))
						0: send_command(sqt_pkg::CMD_POP, 8'($urandom));
						1, 2: send_command(sqt_pkg::CMD_READ, 8'($urandom));
						default: ;
					endcase
				end
			endcase
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// result side: random back-pressure, check every accepted transaction
	initial begin
		key_result_t want;
		int          stall_left;
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, raw_event", m_tdata[7:0], 8'h00);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[7:0] !== want.raw_event)
						report_mismatch("raw_event", m_tdata[7:0], want.raw_event);
					if (m_tdata[15:8] !== want.char_code)
						report_mismatch("char_code", m_tdata[15:8], want.char_code);
					if (m_tuser !== want.char_valid)
						report_mismatch("char_valid", 8'(m_tuser), 8'(want.char_valid));
					if (m_tdata[16] !== want.has_events)
						report_mismatch("has_events", 8'(m_tdata[16]), 8'(want.has_events));
					if (m_tdata[17] !== want.escape_pulse)
						report_mismatch("escape_pulse", 8'(m_tdata[17]),
							8'(want.escape_pulse));
				end
			end
			@(negedge clk);
			if (quiet) begin
				stall_left = 0;
				m_tready   = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready   = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// watchdog: cycles without any transaction on either side
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_MAX) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
